@@ design/temporal_soften_threshold_average_defines.svh @@
// ----------------------------------------------------------------------------
// temporal soften assertion macros
// clocked assertion helpers used by the temporal soften controller
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_SOFTEN_THRESHOLD_AVERAGE_DEFINES_SVH
`define TEMPORAL_SOFTEN_THRESHOLD_AVERAGE_DEFINES_SVH

// plain clocked property, disabled during reset
`define TSTA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define TSTA_ASSERT_IMP(label, cond, conseq, msg) \
	`TSTA_ASSERT(label, (cond) |-> (conseq), msg)

`endif

@@ design/tsta_pkg.sv @@
// ----------------------------------------------------------------------------
// tsta_pkg
// shared constants, register indexes, controller states, command and status types
// ----------------------------------------------------------------------------
package tsta_pkg;

	// parameter defaults
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_FRAMES_DEF  = 16;

	// fixed field widths
	localparam int SAMPLE_W     = 16;
	localparam int OUT_W        = 16;
	localparam int FC_BITS      = 5;
	localparam int THR_BITS     = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_W   = 16;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 1'd1;

	// register reset values
	localparam logic [FC_BITS-1:0]  FRAME_COUNT_RST = 5'd3;
	localparam logic [THR_BITS-1:0] THRESHOLD_RST   = 16'd0;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic start_div;
		logic div_step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic completes;
	} status_t;

endpackage

@@ design/temporal_soften_threshold_average.sv @@
// non-final samples of a group: one word per cycle, no result
// group-closing sample: result word computed by the one-bit-per-cycle restoring divider and
//   loaded once any waiting result word is taken; input held off meanwhile, next word
//   taken after the controller returns to idle
// a waiting result does not block input until the next group closes
// reset: frame_count 3, threshold 0, no open group, no result pending
// ----------------------------------------------------------------------------
// temporal_soften_threshold_average
// threshold-gated temporal average of one pixel position over a frame group
// ----------------------------------------------------------------------------
module temporal_soften_threshold_average #(
	parameter int SAMPLE_BITS = tsta_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_FRAMES  = tsta_pkg::MAX_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsta_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tsta_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tsta_pkg::SAMPLE_W-1:0]     sample,
	input  logic                              first_of_pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tsta_pkg::OUT_W-1:0]        softened_sample
);
	import tsta_pkg::*;

	cmd_t    cmd;
	status_t status;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer
	tsta_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_FRAMES (MAX_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// accumulate and divide
	tsta_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample          (sample),
		.first_of_pixel  (first_of_pixel),
		.cmd             (cmd),
		.status          (status),
		.softened_sample (softened_sample)
	);

endmodule

@@ design/tsta_datapath.sv @@
// ----------------------------------------------------------------------------
// tsta_datapath
// config registers, threshold accumulate, and bit-serial rounding divider
// ----------------------------------------------------------------------------
module tsta_datapath #(
	parameter int SAMPLE_BITS = tsta_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_FRAMES  = tsta_pkg::MAX_FRAMES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [tsta_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tsta_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [tsta_pkg::SAMPLE_W-1:0]      sample,
	input  logic                               first_of_pixel,
	input  tsta_pkg::cmd_t                     cmd,
	output tsta_pkg::status_t                  status,
	output logic [tsta_pkg::OUT_W-1:0]         softened_sample
);
	import tsta_pkg::*;

	localparam int LW  = $clog2(MAX_FRAMES);
	localparam int SW  = SAMPLE_BITS + LW;
	localparam int CW  = $clog2(MAX_FRAMES + 1);
	localparam int FEW = FC_BITS + 1;

	logic [FC_BITS-1:0]     frame_count_q;
	logic [THR_BITS-1:0]    threshold_q;
	logic [SAMPLE_BITS-1:0] center_q;
	logic [SW-1:0]          sum_q;
	logic [CW-1:0]          seen_q;
	logic [CW-1:0]          rem_q;
	logic [SW-1:0]          quo_q;
	logic [CW-1:0]          divisor_q;
	logic [OUT_W-1:0]       softened_q;

	logic [SAMPLE_BITS-1:0] s;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0] addend;
	logic [SW-1:0]          new_sum;
	logic [CW-1:0]          new_seen;
	logic                   open;
	logic [FEW-1:0]         fc_wide;
	logic [FEW-1:0]         fc_eff;
	logic [CW-1:0]          eff;
	logic [SW-1:0]          dividend;
	logic [CW:0]            trial;
	logic                   ge;

	// effective count: zero acts as one, saturate at the frame limit
	always_comb begin
		fc_wide = FEW'(frame_count_q);
		fc_eff  = fc_wide;
		if (fc_wide == '0) begin
			fc_eff = FEW'(1);
		end
		if (fc_wide > FEW'(MAX_FRAMES)) begin
			fc_eff = FEW'(MAX_FRAMES);
		end
		eff = CW'(fc_eff);
	end

	// neighbor select and running sum update
	always_comb begin
		s        = sample[SAMPLE_BITS-1:0];
		diff     = (s >= center_q) ? (s - center_q) : (center_q - s);
		addend   = (THR_BITS'(diff) <= threshold_q) ? s : center_q;
		new_sum  = first_of_pixel ? SW'(s) : (sum_q + SW'(addend));
		new_seen = first_of_pixel ? CW'(1) : (seen_q + CW'(1));
		open     = first_of_pixel || (seen_q != '0);
		dividend = new_sum + SW'(eff >> 1);
	end

	assign status.completes = open && (new_seen >= eff);

	// divider trial subtract
	always_comb begin
		trial = {rem_q, quo_q[SW-1]};
		ge    = (trial >= {1'b0, divisor_q});
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			threshold_q   <= THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FC_BITS-1:0];
				REG_THRESHOLD:   threshold_q   <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
		end else if (cmd.accept && open) begin
			if (first_of_pixel) begin
				center_q <= s;
			end
			if (status.completes) begin
				sum_q  <= '0;
				seen_q <= '0;
			end else begin
				sum_q  <= new_sum;
				seen_q <= new_seen;
			end
		end
	end

	// restoring divider over the full sum width, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= eff;
		end else if (cmd.div_step) begin
			rem_q <= ge ? CW'(trial - {1'b0, divisor_q}) : trial[CW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	// output word register, low bits of the quotient
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			softened_q <= OUT_W'(quo_q);
		end
	end

	assign softened_sample = softened_q;

endmodule

@@ design/tsta_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsta_ctrl
// sequencer for accumulate, divide and output handoff
// ----------------------------------------------------------------------------
`include "temporal_soften_threshold_average_defines.svh"

module tsta_ctrl #(
	parameter int SAMPLE_BITS = tsta_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_FRAMES  = tsta_pkg::MAX_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tsta_pkg::status_t status,
	output tsta_pkg::cmd_t    cmd
);
	import tsta_pkg::*;

	localparam int DIV_STEPS = SAMPLE_BITS + $clog2(MAX_FRAMES);
	localparam int IW = $clog2(DIV_STEPS);
	localparam logic [IW-1:0] LAST_STEP = IW'(DIV_STEPS - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] iter_q, iter_d;
	logic          out_valid_q;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.completes) begin
					cmd.start_div = 1'b1;
					iter_d        = '0;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q + IW'(1);
				if (iter_q == LAST_STEP) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// divide runs a fixed number of steps before handoff
	`TSTA_ASSERT(a_div_len, cmd.start_div |-> ##(DIV_STEPS + 1) (state_q == ST_OUT), "divide length")
	// a waiting word is never overwritten
	`TSTA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_q || out_ready, "word overwritten")
	// a new word only follows a load
	`TSTA_ASSERT(a_valid_src, $rose(out_valid_q) |-> $past(cmd.load_out), "valid without load")

endmodule
